/* design/sem_pkg.sv */
// Package: shared types and constants for the Sobel edge magnitude unit.
package sem_pkg;

    localparam int MAX_WIDTH_DEF = 2048;
    localparam int SUM_W         = 10;
    localparam int GRAD_W        = 13;
    localparam int Q_W           = 25;
    localparam int MAX_HEIGHT    = 4096;
    localparam int LEVEL_MAX     = 255;

    localparam logic [0:0] REG_WIDTH  = 1'b0;
    localparam logic [0:0] REG_HEIGHT = 1'b1;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_t;

    typedef struct packed {
        logic [7:0]  edge_level;
        logic [10:0] center_column;
        logic [11:0] center_row;
        logic        frame_last;
    } result_t;

    // Tag that travels down the square root chain with each item.
    typedef struct packed {
        logic [10:0] center_column;
        logic [11:0] center_row;
        logic        frame_last;
    } tag_t;

endpackage

/* design/sobel_edge_magnitude_unit.sv */
// Top level: Sobel edge magnitude over a streamed RGB frame.
//
//  channel   | valid / ready          | payload
//  ----------+------------------------+----------------------------------
//  pix       | pix_valid / pix_ready  | pix   (red, green, blue)
//  res       | res_valid / res_ready  | res   (edge_level, column, row, last)
//  cfg       | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One pixel per beat. A pixel is taken and the line stores are read into
// registers; then the window shifts and gradients are registered; Q is
// squared into a register, then eight root cells decide one bit each and
// the result register is loaded. The chain moves as a whole; when the
// output register is full and not taken, the chain and the input stall together.
// Reset clears control and the window; line stores are undefined until
// written. A config write restarts the frame counters.
module sobel_edge_magnitude_unit #(
    parameter int MAX_WIDTH = sem_pkg::MAX_WIDTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             pix_valid,
    output logic             pix_ready,
    input  sem_pkg::pixel_t  pix,
    output logic             res_valid,
    input  logic             res_ready,
    output sem_pkg::result_t res,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [0:0]       cfg_index,
    input  logic [12:0]      cfg_data
);
    import sem_pkg::*;

    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int NC = 8;

    logic [11:0] width_reg;
    logic [12:0] height_reg;
    logic [10:0] col_reg;
    logic [11:0] row_reg;
    logic [12:0] w_eff;
    logic [12:0] h_eff;

    logic [SUM_W-1:0] mem_old [MAX_WIDTH];
    logic [SUM_W-1:0] mem_new [MAX_WIDTH];
    logic [SUM_W-1:0] rd_old_reg, rd_new_reg, s_reg;
    logic [AW-1:0]    wb_idx_reg;
    logic             wb_pend_reg;
    logic [SUM_W-1:0] win_reg [3][3];
    logic             s1_valid_reg, s1_emit_reg;
    tag_t             s1_tag_reg;

    logic signed [GRAD_W-1:0] gx_reg, gy_reg;
    logic signed [GRAD_W-1:0] gx, gy;
    logic             s2_valid_reg;
    tag_t             s2_tag_reg;
    logic [Q_W+1:0]   fq_reg;
    logic             s3_valid_reg;
    tag_t             s3_tag_reg;

    logic             advance;
    logic             take;
    logic [AW-1:0]    idx;
    logic [SUM_W-1:0] s;
    logic [11:0]      col_inc;
    logic [10:0]      col_next;
    logic [11:0]      row_next;

    logic             cv [NC+1];
    logic [Q_W+1:0]   cq [NC+1];
    logic [7:0]       cl [NC+1];
    tag_t             ct [NC+1];

    logic             res_valid_reg;
    result_t          res_reg;

    assign cfg_ready = 1'b1;
    assign advance   = !res_valid_reg || res_ready;
    assign pix_ready = advance;
    assign take      = pix_valid && pix_ready;
    assign idx       = col_reg[AW-1:0];
    assign s         = SUM_W'(pix.red) + SUM_W'(pix.green) + SUM_W'(pix.blue);

    always_comb
    begin
        w_eff = {1'b0, width_reg};
        if (w_eff < 13'd3)
            w_eff = 13'd3;
        if (w_eff > 13'(MAX_WIDTH))
            w_eff = 13'(MAX_WIDTH);
        h_eff = height_reg;
        if (h_eff < 13'd3)
            h_eff = 13'd3;
        if (h_eff > 13'(MAX_HEIGHT))
            h_eff = 13'(MAX_HEIGHT);
        // One bit wider so the last column of a full-width row is seen.
        col_inc  = {1'b0, col_reg} + 12'd1;
        col_next = col_inc[10:0];
        row_next = row_reg;
        if ({1'b0, col_inc} >= w_eff)
        begin
            col_next = '0;
            row_next = row_reg + 12'd1;
            if ({1'b0, row_next} >= h_eff)
                row_next = '0;
        end
    end

    // Config and frame counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 12'd640;
            height_reg <= 13'd480;
            col_reg    <= '0;
            row_reg    <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_WIDTH:  width_reg  <= cfg_data[11:0];
                REG_HEIGHT: height_reg <= cfg_data;
                default:    ;
            endcase
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (take)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Older store is written in the cycle after the read, from the registered
    // newer-store data; the same column is not read again before that write.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            wb_pend_reg <= 1'b0;
        else
            wb_pend_reg <= take;
    end

    // Line stores: registered reads, newer store written at the read column.
    always_ff @(posedge clk)
    begin
        if (wb_pend_reg)
            mem_old[wb_idx_reg] <= rd_new_reg;
        if (take)
        begin
            rd_old_reg   <= mem_old[idx];
            rd_new_reg   <= mem_new[idx];
            mem_new[idx] <= s;
            wb_idx_reg   <= idx;
            s_reg        <= s;
            s1_tag_reg.center_column <= col_reg - 11'd1;
            s1_tag_reg.center_row    <= row_reg - 12'd1;
            s1_tag_reg.frame_last    <= ({2'b00, col_reg} == w_eff - 13'd1) &&
                                        ({1'b0, row_reg} == h_eff - 13'd1);
            s1_emit_reg  <= (col_reg >= 11'd2) && (row_reg >= 12'd2);
        end
    end

    // Stage 1 valid; window shift happens when stage 1 moves on.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            for (int r = 0; r < 3; r++)
                for (int c = 0; c < 3; c++)
                    win_reg[r][c] <= '0;
        end
        else if (advance)
        begin
            s1_valid_reg <= take;
            if (s1_valid_reg)
            begin
                for (int r = 0; r < 3; r++)
                begin
                    win_reg[r][0] <= win_reg[r][1];
                    win_reg[r][1] <= win_reg[r][2];
                end
                win_reg[0][2] <= rd_old_reg;
                win_reg[1][2] <= rd_new_reg;
                win_reg[2][2] <= s_reg;
            end
        end
    end

    // Gradients on the window as it stands after the shift.
    always_comb
    begin
        gx = (GRAD_W'(rd_old_reg) + (GRAD_W'(rd_new_reg) << 1) + GRAD_W'(s_reg))
           - (GRAD_W'(win_reg[0][1]) + (GRAD_W'(win_reg[1][1]) << 1)
              + GRAD_W'(win_reg[2][1]));
        gy = (GRAD_W'(win_reg[2][1]) + (GRAD_W'(win_reg[2][2]) << 1) + GRAD_W'(s_reg))
           - (GRAD_W'(win_reg[0][1]) + (GRAD_W'(win_reg[0][2]) << 1)
              + GRAD_W'(rd_old_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s2_valid_reg <= s1_valid_reg && s1_emit_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            gx_reg     <= gx;
            gy_reg     <= gy;
            s2_tag_reg <= s1_tag_reg;
            fq_reg     <= {(Q_W'(gx_reg * gx_reg) + Q_W'(gy_reg * gy_reg)), 2'b00};
            s3_tag_reg <= s2_tag_reg;
        end
    end

    // Chain of root cells, one result bit each, held as a unit on stall.
    assign cv[0] = s3_valid_reg;
    assign cq[0] = fq_reg;
    assign cl[0] = '0;
    assign ct[0] = s3_tag_reg;

    logic             hv [NC];
    logic [Q_W+1:0]   hq [NC];
    logic [7:0]       hl [NC];
    tag_t             ht [NC];
    logic             nv [NC];
    logic [Q_W+1:0]   nq [NC];
    logic [7:0]       nl [NC];
    tag_t             nt [NC];

    for (genvar i = 0; i < NC; i++)
    begin : g_cell
        sem_root_cell #(.BIT(NC - 1 - i)) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .in_valid   (advance ? cv[i] : hv[i]),
            .in_four_q  (advance ? cq[i] : hq[i]),
            .in_level   (advance ? cl[i] : hl[i]),
            .in_tag     (advance ? ct[i] : ht[i]),
            .out_valid  (nv[i]),
            .out_four_q (nq[i]),
            .out_level  (nl[i]),
            .out_tag    (nt[i])
        );
        // Hold path: re-run the cell on its previous input.
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                hv[i] <= 1'b0;
            else if (advance)
                hv[i] <= cv[i];
        end
        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                hq[i] <= cq[i];
                hl[i] <= cl[i];
                ht[i] <= ct[i];
            end
        end
        assign cv[i+1] = nv[i];
        assign cq[i+1] = nq[i];
        assign cl[i+1] = nl[i];
        assign ct[i+1] = nt[i];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (advance)
            res_valid_reg <= cv[NC];
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg.edge_level    <= cl[NC];
            res_reg.center_column <= ct[NC].center_column;
            res_reg.center_row    <= ct[NC].center_row;
            res_reg.frame_last    <= ct[NC].frame_last;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res))
        else $error("result changed while stalled");
    a_no_take_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |-> !pix_ready)
        else $error("pixel taken while output stalled");
    a_cfg_restart: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |=> col_reg == 11'd0 && row_reg == 12'd0)
        else $error("config write did not restart frame");

endmodule

/* design/sem_root_cell.sv */
// One cell of the rounding square root chain: decides one result bit.
module sem_root_cell #(
    parameter int BIT = 7
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic [sem_pkg::Q_W+1:0]   in_four_q,
    input  logic [7:0]                in_level,
    input  sem_pkg::tag_t             in_tag,
    output logic                      out_valid,
    output logic [sem_pkg::Q_W+1:0]   out_four_q,
    output logic [7:0]                out_level,
    output sem_pkg::tag_t             out_tag
);
    import sem_pkg::*;

    logic [7:0]      trial;
    logic [8:0]      odd;
    logic [17:0]     odd_sq;
    logic [21:0]     bound;
    logic            valid_reg;
    logic [Q_W+1:0]  four_q_reg;
    logic [7:0]      level_reg, level_next;
    tag_t            tag_reg;

    // Accept trial bit when 9(2n-1)^2 <= 4Q.
    always_comb
    begin
        trial      = in_level | (8'd1 << BIT);
        odd        = {trial, 1'b0} - 9'd1;
        odd_sq     = odd * odd;
        bound      = {odd_sq, 3'b000} + {4'd0, odd_sq};
        level_next = ({{(Q_W-20){1'b0}}, bound} <= in_four_q) ? trial : in_level;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        four_q_reg <= in_four_q;
        level_reg  <= level_next;
        tag_reg    <= in_tag;
    end

    assign out_valid  = valid_reg;
    assign out_four_q = four_q_reg;
    assign out_level  = level_reg;
    assign out_tag    = tag_reg;

endmodule
